FILE: rtl/sdl_pkg.sv
// shared types and constants of the sorted directory lookup
`timescale 1ns / 1ps
`default_nettype none
package sdl_pkg;

  // key is 8 name characters and 4 extension characters
  localparam int KEY_BYTES = 12;
  localparam int KEY_W     = 8 * KEY_BYTES;

  // item operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 8'd1;

  typedef struct packed {
    logic        op;
    logic [7:0]  entry_index;
    logic [63:0] key_name;
    logic [31:0] key_ext;
    logic [23:0] entry_offset;
    logic [23:0] entry_length;
  } sdl_req_t;

  typedef struct packed {
    logic        found;
    logic [23:0] file_address;
    logic [23:0] file_size;
    logic [7:0]  hit_index;
  } sdl_rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] reg_data;
  } sdl_cfg_t;

  // one stored directory entry
  typedef struct packed {
    logic [63:0] name;
    logic [31:0] ext;
    logic [23:0] offset;
    logic [23:0] length;
  } sdl_entry_t;

endpackage
`default_nettype wire

FILE: rtl/sdl_stream_if.sv
// valid/ready channel carrying one payload item
`timescale 1ns / 1ps
`default_nettype none
interface sdl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/sorted_directory_lookup.sv
// sorted directory lookup top level: entry memory and binary search sequencer
`timescale 1ns / 1ps
`default_nettype none
// Holds up to MAX_ENTRIES directory entries (12-byte key, 24-bit offset, 24-bit
// length) in a single-port memory. A load item (op 0) writes one entry; slots at
// or above MAX_ENTRIES are dropped. A lookup item (op 1) bisects the first
// entry_count entries (saturated at MAX_ENTRIES), which the host must have
// loaded in ascending unsigned big-endian key order. Each probe passes through
// a registered memory read and then the 96-bit key compare; an empty directory
// goes straight to a miss. Probes run one at a time through the memory read
// port and the single key comparator. The input is not ready while a lookup
// is in flight; a finished result sits in the output register so a following
// item is taken while it waits. A hit returns (base_address + offset) mod 2^24,
// the length and the slot; a miss returns all zeros. The entry memory is not
// cleared at reset, so no entry may be searched before it has been loaded.
// Configuration (index 0 entry_count, index 1 base_address) is always ready and
// may be written only while the block is idle.
module sorted_directory_lookup #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  sdl_stream_if.sink   req_i,
  sdl_stream_if.source rsp_o,
  sdl_stream_if.sink   cfg_i
);
  import sdl_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SW = $clog2(MAX_ENTRIES + 1);

  // sequencer state codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PROBE  = 2'd1;
  localparam logic [1:0] ST_CMP    = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  // configuration registers
  logic [8:0]  entry_count_q;
  logic [23:0] base_address_q;

  // search registers
  logic [SW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q;
  logic             last_q;
  logic [KEY_W-1:0] key_q;
  logic             found_q, found_d;
  logic [23:0]      off_q, off_d, len_q, len_d;
  logic [SW-1:0]    hit_q, hit_d;

  // entry memory with registered read
  sdl_entry_t mem [MAX_ENTRIES];
  sdl_entry_t rd_q;

  logic            req_fire, rsp_fire, out_free;
  logic            load_fire, lookup_fire;
  logic [31:0]     slot32, count32, count_sat32;
  logic [SW-1:0]   count_sat;
  logic [SW:0]     mid_sum;
  logic [SW-1:0]   mid_c;
  logic [KEY_W-1:0] entry_key;
  logic            key_lt, key_eq;
  logic [31:0]     hit32;

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_fire    = req_i.valid & req_i.ready;
  assign rsp_fire    = rsp_o.valid & rsp_o.ready;
  assign out_free    = !rsp_o.valid || rsp_o.ready;
  assign load_fire   = req_fire && (req_i.payload.op == OP_LOAD);
  assign lookup_fire = req_fire && (req_i.payload.op == OP_LOOKUP);

  // slot range check and count saturation in 32 bits so any depth works
  assign slot32      = 32'(req_i.payload.entry_index);
  assign count32     = 32'(entry_count_q);
  assign count_sat32 = (count32 > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : count32;
  assign count_sat   = count_sat32[SW-1:0];

  // midpoint of the current window
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c   = mid_sum[SW:1];

  // big-endian key compare: name is the high part
  assign entry_key = {rd_q.name, rd_q.ext};
  assign key_lt    = entry_key < key_q;
  assign key_eq    = entry_key == key_q;

  assign hit32 = 32'(hit_q);

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q  <= '0;
      base_address_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.reg_index)
        REG_ENTRY_COUNT:  entry_count_q  <= cfg_i.payload.reg_data[8:0];
        REG_BASE_ADDRESS: base_address_q <= cfg_i.payload.reg_data;
        default: ;
      endcase
    end
  end

  // entry memory: write on a load item, read on a probe
  always_ff @(posedge clk_i) begin
    if (load_fire && (slot32 < 32'(MAX_ENTRIES))) begin
      mem[slot32[AW-1:0]] <= '{
        name:   req_i.payload.key_name,
        ext:    req_i.payload.key_ext,
        offset: req_i.payload.entry_offset,
        length: req_i.payload.entry_length
      };
    end
    if (state_q == ST_PROBE) begin
      rd_q <= mem[mid_c[AW-1:0]];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    found_d = found_q;
    off_d   = off_q;
    len_d   = len_q;
    hit_d   = hit_q;
    case (state_q)
      ST_IDLE: begin
        if (lookup_fire) begin
          lo_d    = '0;
          hi_d    = count_sat;
          found_d = 1'b0;
          // empty directory goes straight to a miss
          state_d = (count_sat == '0) ? ST_RESULT : ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (key_eq) begin
          found_d = 1'b1;
          off_d   = rd_q.offset;
          len_d   = rd_q.length;
          hit_d   = mid_q;
          state_d = ST_RESULT;
        end else begin
          if (key_lt) begin
            lo_d = mid_q;
          end else begin
            hi_d = mid_q;
          end
          state_d = last_q ? ST_RESULT : ST_PROBE;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    found_q <= found_d;
    off_q   <= off_d;
    len_q   <= len_d;
    hit_q   <= hit_d;
    if (lookup_fire) begin
      key_q <= {req_i.payload.key_name, req_i.payload.key_ext};
    end
    if (state_q == ST_PROBE) begin
      mid_q  <= mid_c;
      last_q <= (mid_c == lo_q);
    end
  end

  // output register, parts the sequencer from the sink
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_o.valid <= 1'b0;
    end else if ((state_q == ST_RESULT) && out_free) begin
      rsp_o.valid <= 1'b1;
    end else if (rsp_fire) begin
      rsp_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESULT) && out_free) begin
      if (found_q) begin
        rsp_o.payload.found        <= 1'b1;
        rsp_o.payload.file_address <= base_address_q + off_q;
        rsp_o.payload.file_size    <= len_q;
        rsp_o.payload.hit_index    <= hit32[7:0];
      end else begin
        rsp_o.payload <= '0;
      end
    end
  end

  // a result only appears after the result state
  a_rsp_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == ST_RESULT))
    else $error("result valid without a finished lookup");

  // the search window never collapses while probing
  a_window_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (lo_q < hi_q))
    else $error("probe with empty search window");

  // a probe is always followed by its compare
  a_probe_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |=> (state_q == ST_CMP))
    else $error("compare did not follow probe");

  // a lookup with a nonempty directory starts probing
  a_lookup_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lookup_fire && (count_sat != '0)) |=> (state_q == ST_PROBE))
    else $error("lookup did not start a search");

endmodule
`default_nettype wire
